// ----- sv/adp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARM data-processing ALU package
// Opcode and shift codes, control struct, flag struct and stream widths.
// ----------------------------------------------------------------------------
package adp_pkg;

	localparam int WORD_W        = 32;
	localparam int IN_FIELDS_W   = 108;
	localparam int IN_TDATA_W    = 112;
	localparam int OUT_FIELDS_W  = 44;
	localparam int OUT_TDATA_W   = 48;

	localparam logic [3:0]        PC_INDEX = 4'd15;
	localparam logic [WORD_W-1:0] PC_AHEAD = 32'd4;

	typedef enum logic [3:0] {
		OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC,
		OP_TST, OP_TEQ, OP_CMP, OP_CMN, OP_ORR, OP_MOV, OP_BIC, OP_MVN
	} alu_op_t;

	typedef enum logic [1:0] {
		SH_LSL, SH_LSR, SH_ASR, SH_ROR
	} shift_kind_t;

	// bit order matches the flag fields: N in bit 3 down to V in bit 0
	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} flags_t;

	typedef struct packed {
		alu_op_t opcode;
		logic    set_flags;
		logic    compare;
		logic    arith;
	} alu_ctrl_t;

endpackage

// ----- sv/adp_shifter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operand-2 barrel shifter
// Rotated immediate, immediate shift or register shift, with shifter carry.
// ----------------------------------------------------------------------------
module adp_shifter (
	input  logic [31:0]                instr,
	input  logic [adp_pkg::WORD_W-1:0] rm_value,
	input  logic [7:0]                 shift_amount_reg,
	input  logic                       carry_in,
	output logic [adp_pkg::WORD_W-1:0] op2,
	output logic                       carry_out
);
	import adp_pkg::*;

	logic [3:0]        rot_field;
	logic [4:0]        rot_amt;
	logic [WORD_W-1:0] imm_value;
	logic              by_reg;
	logic [7:0]        amt;
	logic [4:0]        amt_lo;
	logic              amt_big;
	shift_kind_t       kind;
	logic [WORD_W:0]   lsl_ext;
	logic [WORD_W:0]   lsr_ext;
	logic [WORD_W:0]   asr_ext;
	logic [WORD_W-1:0] ror_val;
	logic [WORD_W-1:0] sign_fill;

	assign rot_field = instr[11:8];
	assign rot_amt   = {rot_field, 1'b0};
	assign imm_value = ({24'd0, instr[7:0]} >> rot_amt) | ({24'd0, instr[7:0]} << (6'd32 - {1'b0, rot_amt}));

	assign by_reg  = instr[4];
	assign kind    = shift_kind_t'(instr[6:5]);
	assign amt     = by_reg ? shift_amount_reg : {3'd0, instr[11:7]};
	assign amt_lo  = amt[4:0];
	assign amt_big = |amt[7:5];

	assign lsl_ext   = {1'b0, rm_value} << amt_lo;
	assign lsr_ext   = {rm_value, 1'b0} >> amt_lo;
	assign asr_ext   = $unsigned($signed({rm_value, 1'b0}) >>> amt_lo);
	assign ror_val   = (rm_value >> amt_lo) | (rm_value << (6'd32 - {1'b0, amt_lo}));
	assign sign_fill = {WORD_W{rm_value[WORD_W-1]}};

	always_comb begin
		op2       = rm_value;
		carry_out = carry_in;
		if (instr[25]) begin
			op2 = imm_value;
			if (rot_field != 4'd0) begin
				carry_out = imm_value[WORD_W-1];
			end
		end else if (amt == 8'd0) begin
			// zero amount: register form passes through, immediate form has special codes
			if (!by_reg) begin
				case (kind)
					SH_LSL: begin
						op2 = rm_value;
					end
					SH_LSR: begin
						op2       = '0;
						carry_out = rm_value[WORD_W-1];
					end
					SH_ASR: begin
						op2       = sign_fill;
						carry_out = rm_value[WORD_W-1];
					end
					default: begin
						op2       = {carry_in, rm_value[WORD_W-1:1]};
						carry_out = rm_value[0];
					end
				endcase
			end
		end else begin
			case (kind)
				SH_LSL: begin
					if (!amt_big && amt_lo != 5'd0) begin
						op2       = lsl_ext[WORD_W-1:0];
						carry_out = lsl_ext[WORD_W];
					end else begin
						op2       = '0;
						carry_out = (amt == 8'd32) ? rm_value[0] : 1'b0;
					end
				end
				SH_LSR: begin
					if (!amt_big && amt_lo != 5'd0) begin
						op2       = lsr_ext[WORD_W:1];
						carry_out = lsr_ext[0];
					end else begin
						op2       = '0;
						carry_out = (amt == 8'd32) ? rm_value[WORD_W-1] : 1'b0;
					end
				end
				SH_ASR: begin
					if (!amt_big && amt_lo != 5'd0) begin
						op2       = asr_ext[WORD_W:1];
						carry_out = asr_ext[0];
					end else begin
						op2       = sign_fill;
						carry_out = rm_value[WORD_W-1];
					end
				end
				default: begin
					op2       = ror_val;
					carry_out = ror_val[WORD_W-1];
				end
			endcase
		end
	end

endmodule

// ----- sv/adp_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARM data-processing ALU
// Sixteen operations on one shared adder, with N Z C V update.
// ----------------------------------------------------------------------------
module adp_alu (
	input  adp_pkg::alu_ctrl_t         ctrl,
	input  logic [adp_pkg::WORD_W-1:0] op1,
	input  logic [adp_pkg::WORD_W-1:0] op2,
	input  logic                       shift_carry,
	input  adp_pkg::flags_t            flags_in,
	output logic [adp_pkg::WORD_W-1:0] result,
	output adp_pkg::flags_t            flags_out
);
	import adp_pkg::*;

	logic [WORD_W-1:0] add_a;
	logic [WORD_W-1:0] add_b;
	logic              add_cin;
	logic [WORD_W-1:0] logic_res;
	logic [WORD_W:0]   sum;
	logic              add_v;

	always_comb begin
		add_a     = op1;
		add_b     = ~op2;
		add_cin   = 1'b1;
		logic_res = '0;
		case (ctrl.opcode)
			OP_AND, OP_TST: begin
				logic_res = op1 & op2;
			end
			OP_EOR, OP_TEQ: begin
				logic_res = op1 ^ op2;
			end
			OP_SUB, OP_CMP: begin
				add_a = op1; add_b = ~op2; add_cin = 1'b1;
			end
			OP_RSB: begin
				add_a = op2; add_b = ~op1; add_cin = 1'b1;
			end
			OP_ADD, OP_CMN: begin
				add_a = op1; add_b = op2; add_cin = 1'b0;
			end
			OP_ADC: begin
				add_a = op1; add_b = op2; add_cin = flags_in.c;
			end
			OP_SBC: begin
				add_a = op1; add_b = ~op2; add_cin = flags_in.c;
			end
			OP_RSC: begin
				add_a = op2; add_b = ~op1; add_cin = flags_in.c;
			end
			OP_ORR: begin
				logic_res = op1 | op2;
			end
			OP_MOV: begin
				logic_res = op2;
			end
			OP_BIC: begin
				logic_res = op1 & ~op2;
			end
			default: begin
				logic_res = ~op2;
			end
		endcase
	end

	assign sum    = {1'b0, add_a} + {1'b0, add_b} + {{WORD_W{1'b0}}, add_cin};
	assign add_v  = ~(add_a[WORD_W-1] ^ add_b[WORD_W-1]) & (add_a[WORD_W-1] ^ sum[WORD_W-1]);
	assign result = ctrl.arith ? sum[WORD_W-1:0] : logic_res;

	always_comb begin
		flags_out = flags_in;
		if (ctrl.set_flags || ctrl.compare) begin
			flags_out.n = result[WORD_W-1];
			flags_out.z = (result == '0);
			if (ctrl.arith) begin
				flags_out.c = sum[WORD_W];
				flags_out.v = add_v;
			end else if (ctrl.set_flags) begin
				flags_out.c = shift_carry;
			end
		end
	end

endmodule

// ----- sv/arm_data_processing_alu_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARM data-processing ALU core
// Executes one ARMv4 data-processing instruction per request: operand-2
// barrel shifter, sixteen ALU operations and N Z C V update.
//
// Channel  Dir  Width  Contents (lowest bits first)
// s_axis   in   112    instr_word, first_operand_value, second_operand_value,
//                      shift_reg_value, flags_in, 4 zero bits
// m_axis   out  48     result_value, result_write, dest_index, flags_out,
//                      restore_status, pc_written, extra_cycle, 4 zero bits
//
// Each request passes through one input register and one result register,
// with the shifter and the 33-bit adder between them.
// One request is accepted every cycle while the output side takes results.
// A stalled result holds in the result register; the input register keeps
// filling until both are full, then s_axis_tready drops.
// Reset (arst_n low) empties both stages at once; no payload is cleared.
// ----------------------------------------------------------------------------
module arm_data_processing_alu_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// instr_word[31:0], first_operand_value[63:32], second_operand_value[95:64],
	// shift_reg_value[103:96], flags_in[107:104], zero[111:108]
	input  logic [adp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// result_value[31:0], result_write[32], dest_index[36:33], flags_out[40:37],
	// restore_status[41], pc_written[42], extra_cycle[43], zero[47:44]
	output logic [adp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import adp_pkg::*;

	// input stage
	logic              valid_s1;
	logic [31:0]       instr_s1;
	logic [WORD_W-1:0] rn_value_s1;
	logic [WORD_W-1:0] rm_value_s1;
	logic [7:0]        rs_byte_s1;
	flags_t            flags_s1;

	// result stage
	logic              valid_s2;
	logic [WORD_W-1:0] result_s2;
	logic              write_s2;
	logic [3:0]        dest_s2;
	flags_t            flags_s2;
	logic              restore_s2;
	logic              pc_written_s2;
	logic              extra_s2;

	logic              take_in;
	logic              stage2_free;
	logic              advance;

	// decode
	alu_op_t           opcode;
	logic              sbit;
	logic [3:0]        rd;
	logic [3:0]        rn;
	logic [3:0]        rm;
	logic              reg_shift;
	alu_ctrl_t         ctrl;
	logic [WORD_W-1:0] op1;
	logic [WORD_W-1:0] rm_adj;
	logic [WORD_W-1:0] op2;
	logic              shift_carry;
	logic [WORD_W-1:0] alu_result;
	flags_t            alu_flags;

	// ---- handshake: the result register frees when taken, the input
	// register frees when it moves on
	assign stage2_free   = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && stage2_free;
	assign s_axis_tready = !valid_s1 || stage2_free;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// capture the request; hold while the input register waits
	always_ff @(posedge clk) begin
		if (take_in) begin
			instr_s1    <= s_axis_tdata[31:0];
			rn_value_s1 <= s_axis_tdata[63:32];
			rm_value_s1 <= s_axis_tdata[95:64];
			rs_byte_s1  <= s_axis_tdata[103:96];
			flags_s1    <= flags_t'(s_axis_tdata[107:104]);
		end
	end

	// ---- decode the held instruction
	assign opcode    = alu_op_t'(instr_s1[24:21]);
	assign sbit      = instr_s1[20];
	assign rn        = instr_s1[19:16];
	assign rd        = instr_s1[15:12];
	assign rm        = instr_s1[3:0];
	assign reg_shift = !instr_s1[25] && instr_s1[4];

	// flags move only with S set and a destination other than the PC;
	// compare forms always write N Z (and C V when arithmetic)
	assign ctrl.opcode    = opcode;
	assign ctrl.set_flags = sbit && (rd != PC_INDEX);
	assign ctrl.compare   = (opcode == OP_TST) || (opcode == OP_TEQ) ||
	                        (opcode == OP_CMP) || (opcode == OP_CMN);
	assign ctrl.arith     = (opcode == OP_SUB) || (opcode == OP_RSB) ||
	                        (opcode == OP_ADD) || (opcode == OP_ADC) ||
	                        (opcode == OP_SBC) || (opcode == OP_RSC) ||
	                        (opcode == OP_CMP) || (opcode == OP_CMN);

	// the register-shift form reads the PC one word further ahead
	assign op1    = (reg_shift && rn == PC_INDEX) ? rn_value_s1 + PC_AHEAD : rn_value_s1;
	assign rm_adj = (reg_shift && rm == PC_INDEX) ? rm_value_s1 + PC_AHEAD : rm_value_s1;

	adp_shifter u_shifter (
		.instr            (instr_s1),
		.rm_value         (rm_adj),
		.shift_amount_reg (rs_byte_s1),
		.carry_in         (flags_s1.c),
		.op2              (op2),
		.carry_out        (shift_carry)
	);

	adp_alu u_alu (
		.ctrl        (ctrl),
		.op1         (op1),
		.op2         (op2),
		.shift_carry (shift_carry),
		.flags_in    (flags_s1),
		.result      (alu_result),
		.flags_out   (alu_flags)
	);

	// ---- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (stage2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2     <= ctrl.compare ? '0 : alu_result;
			write_s2      <= !ctrl.compare;
			dest_s2       <= rd;
			flags_s2      <= alu_flags;
			restore_s2    <= (rd == PC_INDEX) && sbit;
			pc_written_s2 <= (rd == PC_INDEX) && !ctrl.compare;
			extra_s2      <= reg_shift;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, extra_s2, pc_written_s2,
	                        restore_s2, flags_s2, dest_s2, write_s2, result_s2};

endmodule

// ----- sv/adp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARM data-processing ALU port checker
// Watches the stream ports of the core over time; bound to the top level.
// ----------------------------------------------------------------------------
module adp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [adp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import adp_pkg::*;

	// hold a stalled result unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// input backpressure only when the result side is full and stalled
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// an accepted request moves on to the output unless the result side stalls
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("request lost between stages");

	// compare forms write nothing and show a zero result
	a_compare_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[32] |->
			m_axis_tdata[31:0] == '0 && !m_axis_tdata[42])
		else $error("compare form shows a result");

endmodule

bind arm_data_processing_alu_core adp_checker u_adp_checker (.*);

// ----- dv/arm_data_processing_alu_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARM data-processing ALU core testbench
// Sends instruction requests through the input stream. A behavioural model of
// the operand-2 shifter, the ALU and the flag logic predicts each request's
// result. Results are compared field by field, in order, as they leave the
// output stream. Both sides stall at random, with bursts that have no gaps.
// ----------------------------------------------------------------------------
module arm_data_processing_alu_core_tb;
	import adp_pkg::*;

	localparam int CLK_PERIOD  = 4;
	localparam int RESET_CYCLES = 8;
	localparam int IDLE_LIMIT  = 1000; // cycles with no request or result moving
	localparam int TAIL_CYCLES = 8;    // two-stage pipe, plus margin
	localparam int MAX_PRINTED = 40;

	// one result as the model sees it; unpacked from m_axis_tdata by hand
	typedef struct packed {
		logic [31:0] value;
		logic        write;
		logic [3:0]  dest;
		flags_t      flags;
		logic        restore;
		logic        pc_write;
		logic        extra;
	} alu_result_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	alu_result_t pending_results[$];
	int          error_count     = 0;
	int          requests_sent   = 0;
	int          results_checked = 0;
	int          reg_shift_count = 0;
	int          idle_cycles     = 0;
	bit          burst_mode      = 1'b0; // no gaps on either side while set

	arm_data_processing_alu_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Behavioural model
	// ------------------------------------------------------------------------

	function automatic logic [31:0] rotate_right(logic [31:0] value, logic [4:0] amount);
		logic [63:0] doubled;
		doubled = {value, value} >> amount;
		return doubled[31:0];
	endfunction

	// returns {carry, shifted value}; carry_in passes through where C is kept
	function automatic logic [32:0] barrel_shift(logic [31:0] value, shift_kind_t kind,
			logic [7:0] amount, logic by_reg, logic carry_in);
		logic [31:0] shifted;
		if (amount == 8'd0) begin
			// a register amount of zero, or LSL #0, changes nothing
			if (by_reg || kind == SH_LSL)
				return {carry_in, value};
			// immediate LSR #0 and ASR #0 mean 32; ROR #0 is RRX
			case (kind)
				SH_LSR: return {value[31], 32'h0};
				SH_ASR: return {value[31], {32{value[31]}}};
				default: return {value[0], carry_in, value[31:1]};
			endcase
		end
		case (kind)
			SH_LSL: begin
				if (amount < 8'd32)
					return {value[32 - amount], value << amount};
				if (amount == 8'd32)
					return {value[0], 32'h0};
				return 33'h0;
			end
			SH_LSR: begin
				if (amount < 8'd32)
					return {value[amount - 1], value >> amount};
				if (amount == 8'd32)
					return {value[31], 32'h0};
				return 33'h0;
			end
			SH_ASR: begin
				if (amount < 8'd32) begin
					shifted = $signed(value) >>> amount;
					return {value[amount - 1], shifted};
				end
				return {value[31], {32{value[31]}}};
			end
			default: begin
				// a nonzero multiple of 32 leaves the value, carry from bit 31
				shifted = rotate_right(value, amount[4:0]);
				return {shifted[31], shifted};
			end
		endcase
	endfunction

	// returns {overflow, carry, sum}
	function automatic logic [33:0] add_with_carry(logic [31:0] a, logic [31:0] b,
			logic carry_in);
		logic [32:0] sum;
		logic        overflow;
		sum      = {1'b0, a} + {1'b0, b} + {32'h0, carry_in};
		overflow = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
		return {overflow, sum};
	endfunction

	function automatic alu_result_t predict_alu(logic [31:0] instr, logic [31:0] rn_val,
			logic [31:0] rm_val, logic [7:0] rs_byte, flags_t flags_now);
		alu_op_t     opcode;
		logic [3:0]  rn, rd, rm;
		logic [4:0]  rot;
		logic        update_flags, is_compare, is_arith, shifter_c;
		logic [31:0] a, b, res;
		logic [32:0] shifted;
		logic [33:0] sum;
		alu_result_t out;
		opcode       = alu_op_t'(instr[24:21]);
		rn           = instr[19:16];
		rd           = instr[15:12];
		rm           = instr[3:0];
		update_flags = instr[20] && rd != PC_INDEX;
		is_compare   = opcode inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN};
		is_arith     = opcode inside {OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC,
			OP_CMP, OP_CMN};
		a            = rn_val;
		b            = rm_val;
		res          = '0;
		sum          = '0;
		shifter_c    = flags_now.c;
		out          = '0;
		out.extra    = !instr[25] && instr[4];

		if (instr[25]) begin
			rot = {instr[11:8], 1'b0};
			b   = rotate_right({24'h0, instr[7:0]}, rot);
			if (rot != 5'd0)
				shifter_c = b[31];
		end else begin
			if (instr[4]) begin
				// PC reads one word further ahead when Rs supplies the shift
				if (rn == PC_INDEX)
					a = a + PC_AHEAD;
				if (rm == PC_INDEX)
					b = b + PC_AHEAD;
				shifted = barrel_shift(b, shift_kind_t'(instr[6:5]), rs_byte, 1'b1, shifter_c);
			end else
				shifted = barrel_shift(b, shift_kind_t'(instr[6:5]), {3'b0, instr[11:7]},
					1'b0, shifter_c);
			{shifter_c, b} = shifted;
		end

		case (opcode)
			OP_AND, OP_TST: res = a & b;
			OP_EOR, OP_TEQ: res = a ^ b;
			OP_SUB, OP_CMP: sum = add_with_carry(a, ~b, 1'b1);
			OP_RSB:         sum = add_with_carry(b, ~a, 1'b1);
			OP_ADD, OP_CMN: sum = add_with_carry(a, b, 1'b0);
			OP_ADC:         sum = add_with_carry(a, b, flags_now.c);
			OP_SBC:         sum = add_with_carry(a, ~b, flags_now.c);
			OP_RSC:         sum = add_with_carry(b, ~a, flags_now.c);
			OP_ORR:         res = a | b;
			OP_MOV:         res = b;
			OP_BIC:         res = a & ~b;
			default:        res = ~b;
		endcase
		if (is_arith)
			res = sum[31:0];

		// compares always touch the flags; the shifter carry needs S and Rd != PC
		out.flags = flags_now;
		if (update_flags || is_compare) begin
			out.flags.n = res[31];
			out.flags.z = (res == 32'h0);
			if (is_arith) begin
				out.flags.c = sum[32];
				out.flags.v = sum[33];
			end else if (update_flags)
				out.flags.c = shifter_c;
		end

		out.value    = is_compare ? 32'h0 : res;
		out.write    = !is_compare;
		out.dest     = rd;
		out.restore  = rd == PC_INDEX && instr[20];
		out.pc_write = rd == PC_INDEX && !is_compare;
		return out;
	endfunction

	// ------------------------------------------------------------------------
	// Reporting and checking
	// ------------------------------------------------------------------------

	task automatic report_error(string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("[%0t] ERROR: %s", $time, msg);
	endtask

	task automatic compare_field(string field, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s: got %0h, expected %0h",
				results_checked, field, got, want));
	endtask

	// Take each result at the edge where it is accepted and hold it against the
	// oldest prediction.
	always @(posedge clk) begin : check_results
		alu_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.value    = m_axis_tdata[31:0];
			got.write    = m_axis_tdata[32];
			got.dest     = m_axis_tdata[36:33];
			got.flags    = flags_t'(m_axis_tdata[40:37]);
			got.restore  = m_axis_tdata[41];
			got.pc_write = m_axis_tdata[42];
			got.extra    = m_axis_tdata[43];
			if (pending_results.size() == 0)
				report_error($sformatf("result %0d with no request pending: value %08h",
					results_checked, got.value));
			else begin
				want = pending_results.pop_front();
				compare_field("result_value", got.value, want.value);
				compare_field("result_write", 32'(got.write), 32'(want.write));
				compare_field("dest_index", 32'(got.dest), 32'(want.dest));
				compare_field("flags_out", 32'(got.flags), 32'(want.flags));
				compare_field("restore_status", 32'(got.restore), 32'(want.restore));
				compare_field("pc_written", 32'(got.pc_write), 32'(want.pc_write));
				compare_field("extra_cycle", 32'(got.extra), 32'(want.extra));
			end
			results_checked++;
		end
	end

	// End the run if nothing moves on either side for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("Timeout: nothing accepted for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, pending_results.size());
			$display("arm_data_processing_alu_core_tb NOT OK");
			$finish;
		end
	end

	// Output side: draw a stall before each result, then hold ready until one
	// is taken. Lower ready only when a stall is drawn.
	initial begin : result_stalls
		int gap;
		wait (arst_n);
		forever begin
			gap = burst_mode ? 0 : $urandom_range(0, 16);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// Send one request after a random gap and record its prediction once taken.
	task automatic send_request(logic [31:0] instr, logic [31:0] rn_val, logic [31:0] rm_val,
			logic [7:0] rs_byte, logic [3:0] flags_now);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= {4'h0, flags_now, rs_byte, rm_val, rn_val, instr};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(predict_alu(instr, rn_val, rm_val, rs_byte,
			flags_t'(flags_now)));
		requests_sent++;
		if (!instr[25] && instr[4])
			reg_shift_count++;
	endtask

	function automatic logic [31:0] make_instr(alu_op_t op, logic imm, logic s,
			logic [3:0] rn, logic [3:0] rd, logic [11:0] operand_field);
		return {4'hE, 2'b00, imm, op, s, rn, rd, operand_field};
	endfunction

	// Bias operands towards the values where carry and overflow turn.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'h0000_0001;
			5: return 32'hFFFF_FFFC;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] pick_shift_amount();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd32;
			2: return 8'($urandom_range(33, 255));
			3: return 8'd32 * 8'($urandom_range(2, 7));
			4: return 8'd255;
			5, 6: return 8'($urandom_range(1, 31));
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly well-formed instructions with PC registers and shift corner cases
	// mixed in; one in five is raw noise over every bit.
	task automatic send_random_request();
		logic [11:0] operand_field;
		logic [3:0]  rn, rd, rm;
		logic [4:0]  amount;
		logic        imm;
		if ($urandom_range(0, 4) == 0)
			send_request($urandom, $urandom, $urandom, 8'($urandom), 4'($urandom));
		else begin
			rn  = ($urandom_range(0, 4) == 0) ? PC_INDEX : 4'($urandom);
			rd  = ($urandom_range(0, 4) == 0) ? PC_INDEX : 4'($urandom);
			rm  = ($urandom_range(0, 4) == 0) ? PC_INDEX : 4'($urandom);
			imm = 1'b0;
			case ($urandom_range(0, 2))
				0: begin
					imm           = 1'b1;
					operand_field = 12'($urandom);
				end
				1: begin
					amount        = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom);
					operand_field = {amount, 2'($urandom), 1'b0, rm};
				end
				default: operand_field = {4'($urandom), 1'($urandom), 2'($urandom), 1'b1, rm};
			endcase
			send_request({4'($urandom), 2'b00, imm, 4'($urandom), 1'($urandom), rn, rd,
				operand_field}, pick_operand(), pick_operand(), pick_shift_amount(),
				4'($urandom));
		end
	endtask

	// Every opcode at least once, each carrying a shifter or flag corner case.
	task automatic test_directed_cases();
		// rotation of zero keeps C; a nonzero rotation takes C from bit 31
		send_request(make_instr(OP_AND, 1'b1, 1'b1, 4'd1, 4'd2, {4'd0, 8'hFF}),
			32'hFFFF_FFFF, 32'h0, 8'd0, 4'b0010);
		send_request(make_instr(OP_EOR, 1'b1, 1'b1, 4'd1, 4'd2, {4'hF, 8'h80}),
			32'h0, 32'h0, 8'd0, 4'b0000);
		// immediate shift codes: LSL #0, LSR #0, ASR #0, ROR #0 as RRX
		send_request(make_instr(OP_SUB, 1'b0, 1'b1, 4'd1, 4'd2, {5'd0, SH_LSL, 1'b0, 4'd3}),
			32'h8000_0000, 32'h1, 8'd0, 4'b0000);
		send_request(make_instr(OP_RSB, 1'b0, 1'b1, 4'd1, 4'd2, {5'd0, SH_LSR, 1'b0, 4'd3}),
			32'h0, 32'h8000_0001, 8'd0, 4'b0000);
		send_request(make_instr(OP_ADD, 1'b0, 1'b1, 4'd1, 4'd2, {5'd0, SH_ASR, 1'b0, 4'd3}),
			32'hFFFF_FFFF, 32'h8000_0000, 8'd0, 4'b0000);
		send_request(make_instr(OP_ADC, 1'b0, 1'b1, 4'd1, 4'd2, {5'd0, SH_ROR, 1'b0, 4'd3}),
			32'h7FFF_FFFF, 32'h1, 8'd0, 4'b0010);
		// register amounts: zero, exactly 32, above 32, multiples of 32
		send_request(make_instr(OP_SBC, 1'b0, 1'b1, 4'd1, 4'd2, {4'd4, 1'b0, SH_LSL, 1'b1, 4'd3}),
			32'h5, 32'h5, 8'd0, 4'b0010);
		send_request(make_instr(OP_RSC, 1'b0, 1'b1, 4'd1, 4'd2, {4'd4, 1'b0, SH_LSL, 1'b1, 4'd3}),
			32'h0, 32'h1, 8'd32, 4'b0000);
		// compare with S clear still sets N Z; C stays
		send_request(make_instr(OP_TST, 1'b0, 1'b0, 4'd1, 4'd2, {4'd4, 1'b0, SH_LSR, 1'b1, 4'd3}),
			32'hFFFF_FFFF, 32'h8000_0000, 8'd32, 4'b0010);
		send_request(make_instr(OP_TEQ, 1'b0, 1'b1, 4'd1, 4'd2, {4'd4, 1'b0, SH_LSR, 1'b1, 4'd3}),
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd33, 4'b0000);
		send_request(make_instr(OP_CMP, 1'b0, 1'b1, 4'd1, PC_INDEX,
			{4'd4, 1'b0, SH_ASR, 1'b1, 4'd3}), 32'hFFFF_FFFF, 32'h8000_0000, 8'd40, 4'b0000);
		send_request(make_instr(OP_CMN, 1'b0, 1'b0, 4'd1, 4'd2, {4'd4, 1'b0, SH_ROR, 1'b1, 4'd3}),
			32'h7FFF_FFFF, 32'h8000_0001, 8'd64, 4'b0000);
		// PC as destination: status restore with S, no flag update
		send_request(make_instr(OP_ORR, 1'b0, 1'b1, 4'd1, PC_INDEX,
			{5'd1, SH_LSL, 1'b0, 4'd3}), 32'h0, 32'hFFFF_FFFF, 8'd0, 4'b1111);
		send_request(make_instr(OP_MOV, 1'b1, 1'b0, 4'd1, PC_INDEX, {4'd0, 8'h00}),
			32'h0, 32'h0, 8'd0, 4'b0101);
		// PC as Rn and Rm in the register form reads plus four and wraps
		send_request(make_instr(OP_BIC, 1'b0, 1'b1, PC_INDEX, 4'd2,
			{4'd4, 1'b0, SH_LSR, 1'b1, PC_INDEX}), 32'hFFFF_FFFC, 32'hFFFF_FFFC, 8'd1, 4'b0000);
		send_request(make_instr(OP_MVN, 1'b0, 1'b1, 4'd1, 4'd2, {5'd31, SH_ROR, 1'b0, 4'd3}),
			32'h0, 32'h8000_0000, 8'd0, 4'b0000);
		send_request(make_instr(OP_ADD, 1'b0, 1'b1, 4'd1, 4'd2, {4'd4, 1'b0, SH_LSL, 1'b1, 4'd3}),
			32'h1, 32'hFFFF_FFFF, 8'd255, 4'b1111);
		send_request(make_instr(OP_MOV, 1'b0, 1'b1, 4'd1, 4'd2, {5'd31, SH_ASR, 1'b0, 4'd3}),
			32'h0, 32'h4000_0000, 8'd0, 4'b0000);
		send_request(make_instr(OP_MOV, 1'b0, 1'b1, 4'd1, 4'd2, {4'd4, 1'b0, SH_ROR, 1'b1, 4'd3}),
			32'h0, 32'h1, 8'd1, 4'b0000);
		send_request(make_instr(OP_ORR, 1'b0, 1'b1, 4'd1, 4'd2, {4'd4, 1'b0, SH_ROR, 1'b1, 4'd3}),
			32'h0, 32'h8000_0000, 8'd32, 4'b0000);
		// PC in the immediate-shift form gets no adjustment
		send_request(make_instr(OP_ADD, 1'b0, 1'b0, PC_INDEX, 4'd2,
			{5'd0, SH_LSL, 1'b0, PC_INDEX}), 32'h100, 32'h200, 8'd0, 4'b0000);
		send_request(make_instr(OP_SUB, 1'b0, 1'b1, 4'd1, 4'd2, {5'd0, SH_LSL, 1'b0, 4'd3}),
			32'h0, 32'h0, 8'd0, 4'b1001);
		// encodings of other instruction classes still go through the ALU
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF);
		send_request(32'h0000_0000, 32'h0, 32'h0, 8'h00, 4'h0);
	endtask

	task automatic test_random_mix();
		repeat (400) send_random_request();
	endtask

	// Hold the input side until every outstanding result has come back.
	task automatic test_drained_pause();
		repeat (4) begin
			repeat (10) send_random_request();
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while (pending_results.size() != 0) @(posedge clk);
		end
	endtask

	task automatic test_back_to_back_burst();
		burst_mode = 1'b1;
		repeat (60) send_random_request();
		burst_mode = 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_mix();
		test_drained_pause();
		test_back_to_back_burst();

		// drop valid, let the last results drain, then watch for strays
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d instruction requests (%0d with register shifts), checked %0d results",
			requests_sent, reg_shift_count, results_checked);
		$display("Covered all opcodes, three operand-2 forms, shift corner codes and PC operands");
		if (error_count == 0)
			$display("arm_data_processing_alu_core_tb OK");
		else
			$display("arm_data_processing_alu_core_tb NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/adp_pkg.sv
sv/adp_shifter.sv
sv/adp_alu.sv
sv/arm_data_processing_alu_core.sv
sv/adp_checker.sv
dv/arm_data_processing_alu_core_tb.sv
